// ===== rtl/umf_pkg.sv =====
// shared types and codes for the unique mode finder
`timescale 1ns / 1ps

package umf_pkg;

  localparam int CNT_W = 7;
  localparam int OUT_W = 32;

  localparam logic [1:0] ST_UNIQUE = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_MULTI  = 2'd2;

  // flags of a sample travelling down the cell row
  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

  // tally entry held in one cell
  typedef struct packed {
    logic             used;
    logic [CNT_W-1:0] cnt;
  } ent_t;

endpackage

// ===== rtl/umf_cell.sv =====
// one tally cell: matches a passing sample, claims it when free, shifts out on scan
`timescale 1ns / 1ps

module umf_cell import umf_pkg::*; #(
  parameter int KW        = 32,
  parameter int CNT_LIMIT = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  tok_t          tok_in,
  input  logic [KW-1:0] tok_val_in,
  output tok_t          tok_out,
  output logic [KW-1:0] tok_val_out,
  input  ent_t          nb_in,
  input  logic [KW-1:0] nb_val_in,
  output ent_t          ent,
  output logic [KW-1:0] ent_val
);

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(CNT_LIMIT);

  logic match;
  logic claim;

  assign match = ent.used && tok_in.valid && (ent_val == tok_val_in);
  // first free cell takes a sample that no earlier cell holds
  assign claim = tok_in.valid && !tok_in.found && !ent.used;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      ent     <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found || match || claim;
      if (shift) begin
        ent <= nb_in;
      end else if (claim) begin
        ent.used <= 1'b1;
        ent.cnt  <= CNT_W'(1);
      end else if (match && (ent.cnt < LIMIT)) begin
        ent.cnt <= ent.cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_val_out <= tok_val_in;
    if (shift) begin
      ent_val <= nb_val_in;
    end else if (claim) begin
      ent_val <= tok_val_in;
    end
  end

endmodule

// ===== rtl/umf_best.sv =====
// running maximum of the tallies shifted out of the row, with a tie flag
`timescale 1ns / 1ps

module umf_best import umf_pkg::*; #(
  parameter int KW = 32
) (
  input  logic             clk,
  input  logic             clear,
  input  logic             en,
  input  ent_t             ent,
  input  logic [KW-1:0]    ent_val,
  output logic [CNT_W-1:0] best_cnt,
  output logic [KW-1:0]    best_val,
  output logic             multi
);

  always_ff @(posedge clk) begin
    if (clear) begin
      best_cnt <= '0;
      best_val <= '0;
      multi    <= 1'b0;
    end else if (en && ent.used) begin
      if (ent.cnt > best_cnt) begin
        best_cnt <= ent.cnt;
        best_val <= ent_val;
        multi    <= 1'b0;
      end else if (ent.cnt == best_cnt) begin
        multi <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/unique_mode_finder.sv =====
// top level: row of tally cells, drain and scan sequencer, result register
//
//   channel  valid      stall      payload
//   in       in_valid   in_stall   sample, last_item
//   out      out_valid  out_stall  mode_value, mode_count, status
//
// one item per cycle is taken while a set streams in; each sample walks the
// cell row one cell per cycle. after the last item the block stalls its input
// while it lets the last sample leave the row, shifts every tally into the
// maximum unit and loads the result. the scan leaves the row empty, so the
// next set starts clean. reset is synchronous and empties the row. a stalled
// result holds the block in its final step until the result is taken.
`timescale 1ns / 1ps

module unique_mode_finder import umf_pkg::*; #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [OUT_W-1:0] sample,
  input  logic                    last_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] mode_value,
  output logic [CNT_W-1:0]        mode_count,
  output logic [1:0]              status
);

  localparam int KW        = (VALUE_WIDTH < OUT_W) ? VALUE_WIDTH : OUT_W;
  localparam int CNT_LIMIT = (MAX_ITEMS < 127) ? MAX_ITEMS : 127;
  localparam int PW        = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [PW-1:0] STEP_END = PW'(MAX_ITEMS - 1);

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state;
  logic [PW-1:0] step;
  logic          zero_seen;
  tok_t          in_tok;
  logic [KW-1:0] in_val;
  logic          in_acc;
  logic          out_free;
  logic          shift;
  logic [KW-1:0] sample_low;

  tok_t          toks  [0:MAX_ITEMS];
  logic [KW-1:0] tvals [0:MAX_ITEMS];
  ent_t          ents  [0:MAX_ITEMS];
  logic [KW-1:0] evals [0:MAX_ITEMS];

  logic [CNT_W-1:0] best_cnt;
  logic [KW-1:0]    best_val;
  logic             multi;

  assign sample_low = sample[KW-1:0];
  assign in_stall   = (state != S_RUN);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign shift      = (state == S_SCAN);

  assign toks[0]  = in_tok;
  assign tvals[0] = in_val;
  // the far end feeds empty entries during the scan
  assign ents[MAX_ITEMS]  = '0;
  assign evals[MAX_ITEMS] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    umf_cell #(
      .KW        (KW),
      .CNT_LIMIT (CNT_LIMIT)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (shift),
      .tok_in      (toks[i]),
      .tok_val_in  (tvals[i]),
      .tok_out     (toks[i+1]),
      .tok_val_out (tvals[i+1]),
      .nb_in       (ents[i+1]),
      .nb_val_in   (evals[i+1]),
      .ent         (ents[i]),
      .ent_val     (evals[i])
    );
  end

  umf_best #(
    .KW (KW)
  ) u_best (
    .clk      (clk),
    .clear    (state == S_DRAIN),
    .en       (shift),
    .ent      (ents[0]),
    .ent_val  (evals[0]),
    .best_cnt (best_cnt),
    .best_val (best_val),
    .multi    (multi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      step      <= '0;
      zero_seen <= 1'b0;
      in_tok    <= '0;
      out_valid <= 1'b0;
    end else begin
      in_tok.valid <= in_acc;
      in_tok.found <= 1'b0;
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (in_acc) begin
            if (sample_low == '0) begin
              zero_seen <= 1'b1;
            end
            if (last_item) begin
              state <= S_DRAIN;
              step  <= '0;
            end
          end
        end
        S_DRAIN: begin
          if (step == STEP_END) begin
            state <= S_SCAN;
            step  <= '0;
          end else begin
            step <= step + PW'(1);
          end
        end
        S_SCAN: begin
          if (step == STEP_END) begin
            state <= S_DONE;
            step  <= '0;
          end else begin
            step <= step + PW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            zero_seen <= 1'b0;
            state     <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_val <= sample_low;
    end
  end

  // result register, loaded after the scan once the output is free
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      if (zero_seen) begin
        mode_value <= '0;
        mode_count <= '0;
        status     <= ST_ZERO;
      end else if (multi) begin
        mode_value <= '0;
        mode_count <= best_cnt;
        status     <= ST_MULTI;
      end else begin
        mode_value <= OUT_W'(best_val);
        mode_count <= best_cnt;
        status     <= ST_UNIQUE;
      end
    end
  end

endmodule

// ===== tb/tb_unique_mode_finder.sv =====
// testbench for the unique mode finder: queued sets, tally prediction, per-field checking
`timescale 1ns / 1ps

module tb_unique_mode_finder;
  import umf_pkg::*;

  localparam int MAX_ITEMS   = 64;
  localparam int CNT_CAP     = (MAX_ITEMS < 127) ? MAX_ITEMS : 127;
  localparam int SCAN_CYCLES = 2 * MAX_ITEMS + 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1100;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [OUT_W-1:0] value;
    logic             last;
  } sample_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] mode_value;
    logic [CNT_W-1:0]        mode_count;
    logic [1:0]              status;
  } mode_result_t;

  logic clk;
  logic rst;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [OUT_W-1:0] sample = '0;
  logic last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] mode_value;
  logic [CNT_W-1:0] mode_count;
  logic [1:0] status;

  sample_item_t sample_feed[$];
  mode_result_t expected_modes[$];

  // own copy of the tally table
  logic [OUT_W-1:0] tally_vals[MAX_ITEMS];
  int               tally_cnts[MAX_ITEMS];
  int               tally_used = 0;
  bit               zero_seen = 0;

  int total_items = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int idle_phase;
  int send_gap_pct;
  int stall_pct;

  unique_mode_finder #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_WIDTH(32)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .last_item (last_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mode_value(mode_value),
    .mode_count(mode_count),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // idling phases follow progress through the queued items
  assign idle_phase   = (total_items == 0) ? 0 : (accepted_cnt * 4) / total_items;
  assign send_gap_pct = (idle_phase == 1) ? 55 : (idle_phase >= 3) ? 36 : 0;
  assign stall_pct    = (idle_phase == 2) ? 55 : (idle_phase >= 3) ? 36 : 0;

  task automatic tally_sample(input logic [OUT_W-1:0] v, input logic last);
    int i;
    bit found;
    int best;
    int ties;
    logic [OUT_W-1:0] best_val;
    mode_result_t r;
    found = 0;
    if (v == '0) zero_seen = 1;
    for (i = 0; i < tally_used; i++) begin
      if (tally_vals[i] == v) begin
        if (tally_cnts[i] < CNT_CAP) tally_cnts[i]++;
        found = 1;
      end
    end
    // a new value is dropped once the table is full
    if (!found && tally_used < MAX_ITEMS) begin
      tally_vals[tally_used] = v;
      tally_cnts[tally_used] = 1;
      tally_used++;
    end
    if (last) begin
      best = 0;
      ties = 0;
      best_val = '0;
      for (i = 0; i < tally_used; i++) begin
        if (tally_cnts[i] > best) begin
          best = tally_cnts[i];
          best_val = tally_vals[i];
        end
      end
      for (i = 0; i < tally_used; i++) begin
        if (tally_cnts[i] == best) ties++;
      end
      if (zero_seen) begin
        r.status = ST_ZERO;
        r.mode_value = '0;
        r.mode_count = '0;
      end else if (ties > 1) begin
        r.status = ST_MULTI;
        r.mode_value = '0;
        r.mode_count = CNT_W'(best);
      end else begin
        r.status = ST_UNIQUE;
        r.mode_value = best_val;
        r.mode_count = CNT_W'(best);
      end
      expected_modes.push_back(r);
      for (i = 0; i < MAX_ITEMS; i++) tally_cnts[i] = 0;
      tally_used = 0;
      zero_seen = 0;
    end
  endtask

  task automatic queue_item(input logic [OUT_W-1:0] v, input logic last);
    sample_item_t it;
    it.value = v;
    it.last = last;
    sample_feed.push_back(it);
  endtask

  // sender
  always @(posedge clk) begin
    sample_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      accepted_cnt <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        tally_sample(sample, last_item);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (sample_feed.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          it = sample_feed.pop_front();
          in_valid <= 1'b1;
          sample <= it.value;
          last_item <= it.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    mode_result_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_modes.size() == 0) begin
          $error("unexpected result: mode_value %0d, mode_count %0d, status %0d",
                 mode_value, mode_count, status);
          err_cnt++;
        end else begin
          exp_r = expected_modes.pop_front();
          if (mode_value !== exp_r.mode_value) begin
            $error("mode_value expected %0d, got %0d", exp_r.mode_value, mode_value);
            err_cnt++;
          end
          if (mode_count !== exp_r.mode_count) begin
            $error("mode_count expected %0d, got %0d", exp_r.mode_count, mode_count);
            err_cnt++;
          end
          if (status !== exp_r.status) begin
            $error("status expected %0d, got %0d", exp_r.status, status);
            err_cnt++;
          end
        end
      end
      // one long hold-off early on so the block backs up into its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall && results_seen == 1) begin
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [OUT_W-1:0] pool[80];
    int n_pool;
    int len;
    int kind;
    int k;
    int i;
    logic [OUT_W-1:0] v;

    // directed sets
    queue_item(32'd5, 1'b1);
    queue_item(32'd0, 1'b1);
    queue_item(32'h7fffffff, 1'b0);
    queue_item(32'h80000000, 1'b0);
    queue_item(32'h80000000, 1'b1);
    // tie between all-ones and one
    queue_item(32'hffffffff, 1'b0);
    queue_item(32'd1, 1'b0);
    queue_item(32'hffffffff, 1'b0);
    queue_item(32'd1, 1'b1);
    // zero inside a set with a clear winner
    queue_item(32'd7, 1'b0);
    queue_item(32'd0, 1'b0);
    queue_item(32'd7, 1'b1);
    queue_item(32'hffffffff, 1'b0);
    queue_item(32'hffffffff, 1'b0);
    queue_item(32'hffffffff, 1'b1);
    queue_item(32'h7fffffff, 1'b0);
    queue_item(32'h7fffffff, 1'b0);
    queue_item(32'h00000002, 1'b1);

    while (sample_feed.size() < ITEM_TARGET) begin
      kind = $urandom_range(19);
      if (kind == 0) begin
        // fills the table, then draws from 80 values, more than the table holds
        for (k = 0; k < 80; k++) pool[k] = $urandom;
        len = $urandom_range(66, 100);
        for (i = 0; i < len; i++) begin
          v = (i < MAX_ITEMS) ? pool[i] : pool[$urandom_range(79)];
          queue_item(v, i == len - 1);
        end
      end else if (kind == 1) begin
        // one value repeated, often past the count cap
        pool[0] = $urandom;
        pool[1] = $urandom;
        if ($urandom_range(3) == 0) pool[1] = '0;
        len = $urandom_range(65, 100);
        for (i = 0; i < len; i++) begin
          v = ($urandom_range(9) < 9) ? pool[0] : pool[1];
          queue_item(v, i == len - 1);
        end
      end else begin
        n_pool = $urandom_range(1, 6);
        for (k = 0; k < n_pool; k++) begin
          pool[k] = $urandom;
          case ($urandom_range(23))
            0: pool[k] = '0;
            1: pool[k] = 32'h80000000;
            2: pool[k] = 32'h7fffffff;
            3: pool[k] = 32'hffffffff;
            4: pool[k] = 32'd1;
            default: ;
          endcase
        end
        len = $urandom_range(1, 24);
        for (i = 0; i < len; i++) queue_item(pool[$urandom_range(n_pool - 1)], i == len - 1);
      end
    end
    total_items = sample_feed.size();

    while (sample_feed.size() > 0 || in_valid) @(posedge clk);
    while (expected_modes.size() > 0) @(posedge clk);
    repeat (SCAN_CYCLES + 16) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/umf_pkg.sv
rtl/umf_cell.sv
rtl/umf_best.sv
rtl/unique_mode_finder.sv
tb/tb_unique_mode_finder.sv
